/* sv/tmhq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ternary min-heap queue.
// No dependencies; every other file imports this package.
package tmhq_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int DW    = 32;
  localparam int CAP_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_TOP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [DW-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DW-1:0] result_value;
    logic [1:0]           status;
    logic [CAP_W-1:0]     occupancy;
  } out_beat_t;

endpackage

/* sv/tmhq_regs.sv */
`timescale 1ns / 1ps
// APB register file: holds the capacity register.
// Depends on tmhq_pkg.
module tmhq_regs
  import tmhq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CAP_W-1:0] capacity
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

endmodule

/* sv/tmhq_engine.sv */
`timescale 1ns / 1ps
// Heap engine: heap memory, element count and the sift sequencer.
// Depends on tmhq_pkg.
module tmhq_engine
  import tmhq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_beat_t         req,
  output logic             done,
  output out_beat_t        rsp,
  input  logic [CAP_W-1:0] capacity
);

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int RW = AW + 1;
  localparam logic [RW-1:0] RECIP = RW'((2 ** (AW + 2)) / 3 + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_PO_RD0, S_PO_RD1, S_PO_LAST,
    S_TP_RD, S_TP_OUT, S_DN_SCAN, S_DN_DEC
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [AW-1:0]        par;
  logic signed [DW-1:0] val;
  logic signed [DW-1:0] res;
  logic [AW+1:0]        base;
  logic [1:0]           j;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic [AW-1:0]        best_idx;
  logic signed [DW-1:0] best_val;
  logic                 have_best;

  logic [DW-1:0]        mem [DEPTH];
  logic signed [DW-1:0] rdata;
  logic                 ren;
  logic [AW-1:0]        raddr;
  logic                 wen;
  logic [AW-1:0]        waddr;
  logic [DW-1:0]        wdata;

  logic [LW-1:0]        limit;
  logic [AW-1:0]        parent;
  logic [2*AW+1:0]      prod;
  logic [AW+1:0]        scan_addr;
  logic                 issue;
  logic [AW+1:0]        child_base;

  assign busy  = (state != S_IDLE);
  assign limit = (LW'(capacity) < LW'(DEPTH)) ? LW'(capacity) : LW'(DEPTH);

  // parent = (pos - 1) / 3 by reciprocal multiply
  assign prod   = (2*AW+2)'(pos - AW'(1)) * (2*AW+2)'(RECIP);
  assign parent = prod[AW+2 +: AW];

  assign scan_addr  = base + (AW+2)'(j);
  assign issue      = (j != 2'd3) && (scan_addr < (AW+2)'(count));
  assign child_base = {1'b0, best_idx, 1'b0} + {2'b00, best_idx} + (AW+2)'(1);

  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    wen   = 1'b0;
    waddr = pos;
    wdata = val;
    case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          wen = 1'b1;
        end else begin
          ren   = 1'b1;
          raddr = parent;
        end
      end
      S_UP_CMP: begin
        wen = 1'b1;
        if (val < rdata) begin
          wdata = rdata;
        end
      end
      S_PO_RD0: begin
        ren = 1'b1;
      end
      S_PO_RD1: begin
        ren   = 1'b1;
        raddr = count[AW-1:0];
      end
      S_TP_RD: begin
        ren = 1'b1;
      end
      S_DN_SCAN: begin
        ren   = issue;
        raddr = scan_addr[AW-1:0];
      end
      S_DN_DEC: begin
        wen = 1'b1;
        if (have_best && (best_val < val)) begin
          wdata = best_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (req.mode)
              MODE_PUSH: begin
                if (LW'(count) >= limit) begin
                  done <= 1'b1;
                  rsp  <= '{result_value: '0, status: ST_FULL,
                            occupancy: CAP_W'(count)};
                end else begin
                  count <= count + CW'(1);
                  pos   <= count[AW-1:0];
                  val   <= req.push_value;
                  state <= S_UP_RD;
                end
              end
              MODE_POP, MODE_TOP: begin
                if (count == '0) begin
                  done <= 1'b1;
                  rsp  <= '{result_value: '0, status: ST_EMPTY,
                            occupancy: CAP_W'(count)};
                end else if (req.mode == MODE_POP) begin
                  count <= count - CW'(1);
                  state <= S_PO_RD0;
                end else begin
                  state <= S_TP_RD;
                end
              end
              default: begin
                done <= 1'b1;
                rsp  <= '{result_value: '0, status: ST_OK, occupancy: CAP_W'(count)};
              end
            endcase
          end
        end
        S_UP_RD: begin
          if (pos == '0) begin
            done  <= 1'b1;
            rsp   <= '{result_value: '0, status: ST_OK, occupancy: CAP_W'(count)};
            state <= S_IDLE;
          end else begin
            par   <= parent;
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (val < rdata) begin
            pos   <= par;
            state <= S_UP_RD;
          end else begin
            done  <= 1'b1;
            rsp   <= '{result_value: '0, status: ST_OK, occupancy: CAP_W'(count)};
            state <= S_IDLE;
          end
        end
        S_PO_RD0: begin
          state <= S_PO_RD1;
        end
        S_PO_RD1: begin
          res   <= rdata;
          state <= S_PO_LAST;
        end
        S_PO_LAST: begin
          val <= rdata;
          if (count == '0) begin
            done  <= 1'b1;
            rsp   <= '{result_value: res, status: ST_OK, occupancy: CAP_W'(count)};
            state <= S_IDLE;
          end else begin
            pos       <= '0;
            base      <= (AW+2)'(1);
            j         <= '0;
            pend      <= 1'b0;
            have_best <= 1'b0;
            state     <= S_DN_SCAN;
          end
        end
        S_TP_RD: begin
          state <= S_TP_OUT;
        end
        S_TP_OUT: begin
          done  <= 1'b1;
          rsp   <= '{result_value: rdata, status: ST_OK, occupancy: CAP_W'(count)};
          state <= S_IDLE;
        end
        S_DN_SCAN: begin
          if (pend && (!have_best || (rdata < best_val))) begin
            best_val  <= rdata;
            best_idx  <= pend_idx;
            have_best <= 1'b1;
          end
          if (issue) begin
            pend     <= 1'b1;
            pend_idx <= scan_addr[AW-1:0];
            j        <= j + 2'd1;
          end else begin
            pend <= 1'b0;
          end
          if (!pend && !issue) begin
            state <= S_DN_DEC;
          end
        end
        S_DN_DEC: begin
          if (have_best && (best_val < val)) begin
            pos       <= best_idx;
            base      <= child_base;
            j         <= '0;
            pend      <= 1'b0;
            have_best <= 1'b0;
            state     <= S_DN_SCAN;
          end else begin
            done  <= 1'b1;
            rsp   <= '{result_value: res, status: ST_OK, occupancy: CAP_W'(count)};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CW'(1))
             || (count + CW'(1) == $past(count)))
    else $error("element count moved by more than one");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while sequencer active");

  a_full_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.mode == MODE_PUSH) && (LW'(count) >= limit))
      |=> (done && (rsp.status == ST_FULL)))
    else $error("full push did not reply next cycle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DN_SCAN) && issue) |-> (scan_addr < (AW+2)'(count)))
    else $error("child read beyond element count");
`endif

endmodule

/* sv/ternary_min_heap_queue.sv */
`timescale 1ns / 1ps
// Ternary min-heap priority queue: top level joining registers and heap engine.
// Depends on tmhq_pkg, tmhq_regs and tmhq_engine.
// Each command is taken when start is high and busy is low, and yields exactly one
// result, strobed on done for a single cycle; the receiver cannot stall it, so
// capture rsp whenever done is high. A full push, an empty pop or top, and an
// unknown mode answer straight from idle without touching the heap memory; top
// reads the root; push climbs one level per parent read and stops at the root
// or below it; pop reads the root and the last element and, unless it removed
// the last element, sifts down level by level. The heap memory has one read
// port, which serves one read per cycle, so each level reads the parent or the
// up-to-three children one after another.
module ternary_min_heap_queue
  import tmhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_beat_t    req,
  output logic        done,
  output out_beat_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0] capacity;

  tmhq_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  tmhq_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .capacity (capacity)
  );

endmodule

/* verif/tb_ternary_min_heap_queue.sv */
`timescale 1ns / 1ps
// Self-checking bench for ternary_min_heap_queue: drives push/pop/top commands and
// capacity writes, predicts each result with a behavioral ternary heap and compares.
// Depends on tmhq_pkg and the ternary_min_heap_queue RTL.
module tb_ternary_min_heap_queue;
  import tmhq_pkg::*;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [2:0] CAP_ADDR     = 3'(4 * REG_CAPACITY);
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         TAIL_CYCLES  = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_beat_t    req = '0;
  logic        done;
  out_beat_t   rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ternary_min_heap_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_beat_t          cmds_pending[$];
  out_beat_t         replies_due[$];
  logic signed [DW-1:0] heap_mem [DEPTH];
  int unsigned       heap_cnt = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  int                idle_pct = 0;
  int                mismatches = 0;
  int                cycles = 0;
  logic              beat_taken = 1'b0;

  task automatic heap_apply(input in_beat_t b);
    out_beat_t            r;
    int unsigned          lim, pos, par, best, k;
    logic signed [DW-1:0] tmp;
    bit                   moving;
    r = '0;
    lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    case (b.mode)
      MODE_PUSH: begin
        if (heap_cnt >= lim) begin
          r.status = ST_FULL;
        end else begin
          heap_mem[heap_cnt] = b.push_value;
          pos = heap_cnt;
          heap_cnt++;
          moving = 1'b1;
          while (moving && pos > 0) begin
            par = (pos - 1) / 3;
            if (heap_mem[pos] < heap_mem[par]) begin
              tmp = heap_mem[par];
              heap_mem[par] = heap_mem[pos];
              heap_mem[pos] = tmp;
              pos = par;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      MODE_POP: begin
        if (heap_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value = heap_mem[0];
          heap_cnt--;
          heap_mem[0] = heap_mem[heap_cnt];
          pos = 0;
          moving = 1'b1;
          while (moving && 3 * pos + 1 < heap_cnt) begin
            best = 3 * pos + 1;
            for (k = best + 1; k <= 3 * pos + 3 && k < heap_cnt; k++) begin
              if (heap_mem[k] < heap_mem[best]) best = k;
            end
            if (heap_mem[best] < heap_mem[pos]) begin
              tmp = heap_mem[pos];
              heap_mem[pos] = heap_mem[best];
              heap_mem[best] = tmp;
              pos = best;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      MODE_TOP: begin
        if (heap_cnt == 0) r.status = ST_EMPTY;
        else r.result_value = heap_mem[0];
      end
      default: ;
    endcase
    r.occupancy = heap_cnt[CAP_W-1:0];
    replies_due.push_back(r);
  endtask

  task automatic check_reply(input out_beat_t got);
    out_beat_t want;
    if (replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with none due: value %0d status %0d occupancy %0d",
                 $realtime, got.result_value, got.status, got.occupancy);
    end else begin
      want = replies_due.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: want value %0d status %0d occupancy %0d, got %0d %0d %0d",
                   $realtime, want.result_value, want.status, want.occupancy,
                   got.result_value, got.status, got.occupancy);
      end
    end
  endtask

  // driver: hold start until the beat is taken, then advance or idle
  always @(negedge clk) begin
    if (!rst && (!start || beat_taken)) begin
      if (cmds_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req <= cmds_pending.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (start && !busy) heap_apply(req);
      if (done) check_reply(rsp);
    end
  end

  function automatic logic signed [DW-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) rand_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else if (pick < 3) rand_value = DW'($urandom_range(16)) - DW'(8);
    else rand_value = $urandom;
  endfunction

  task automatic add_cmd(input logic [1:0] mode, input logic signed [DW-1:0] v);
    in_beat_t b;
    b.mode = mode;
    b.push_value = v;
    cmds_pending.push_back(b);
  endtask

  task automatic add_mix(input int n, input int push_pct, input int pop_pct);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < push_pct) add_cmd(MODE_PUSH, rand_value());
      else if (roll < push_pct + pop_pct) add_cmd(MODE_POP, rand_value());
      else if (roll < 98) add_cmd(MODE_TOP, rand_value());
      else add_cmd(MODE_UNKNOWN, rand_value());
    end
  endtask

  task automatic settle();
    while (cmds_pending.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic drain_heap();
    repeat (heap_cnt) add_cmd(MODE_POP, rand_value());
    settle();
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int pushes;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 0;
    add_cmd(MODE_POP, 32'sd0);
    add_cmd(MODE_TOP, 32'sd0);
    add_cmd(MODE_UNKNOWN, 32'sd0);
    add_cmd(MODE_PUSH, 32'h7FFF_FFFF);
    add_cmd(MODE_PUSH, 32'h8000_0000);
    add_cmd(MODE_PUSH, 32'sd0);
    add_cmd(MODE_PUSH, -32'sd1);
    add_cmd(MODE_PUSH, 32'sd5);
    add_cmd(MODE_PUSH, 32'sd5);
    add_cmd(MODE_PUSH, 32'sd5);
    add_cmd(MODE_PUSH, 32'sd3);
    add_cmd(MODE_TOP, 32'sd0);
    add_cmd(MODE_UNKNOWN, -32'sd1);
    repeat (9) add_cmd(MODE_POP, 32'sd0);
    add_cmd(MODE_TOP, 32'sd0);
    settle();

    write_capacity(CAP_W'(1024));
    idle_pct = 0;
    add_mix(40, 55, 35);
    settle();
    drain_heap();

    write_capacity(CAP_W'(3));
    idle_pct = 82;
    add_mix(30, 50, 40);
    settle();
    drain_heap();

    write_capacity(CAP_W'(1));
    idle_pct = 27;
    add_mix(20, 50, 40);
    settle();
    drain_heap();

    write_capacity(CAP_W'(0));
    idle_pct = 0;
    add_mix(10, 50, 40);
    settle();

    // fill past the store depth with a capacity above it
    write_capacity(CAP_W'(2047));
    idle_pct = 27;
    pushes = 0;
    while (pushes < DEPTH + 4) begin
      if ($urandom_range(99) < 3) begin
        add_cmd(MODE_TOP, rand_value());
      end else begin
        add_cmd(MODE_PUSH, rand_value());
        pushes++;
      end
    end
    settle();

    // capacity below the current count
    write_capacity(CAP_W'(40));
    idle_pct = 82;
    add_mix(30, 30, 60);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0d results never arrived", replies_due.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
